FILE: hw/rtl/acbc_pkg.sv
`timescale 1ns / 1ps

package acbc_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int BLOCK_BITS  = 8 * BLOCK_BYTES;
    localparam int ROUNDS      = 10;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        REG_KEY_UPPER    = 3'd0,
        REG_KEY_LOWER    = 3'd1,
        REG_IV_UPPER     = 3'd2,
        REG_IV_LOWER     = 3'd3,
        REG_DECRYPT_MODE = 3'd4,
        REG_PAD_ENABLE   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [BLOCK_BITS-1:0] data;
        logic                  last;
        logic                  first;
        logic                  decrypt;
    } cmd_t;

    typedef struct packed {
        logic [BLOCK_BITS-1:0] key;
        logic [BLOCK_BITS-1:0] iv;
        logic                  key_wr;
    } core_cfg_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [BLOCK_BITS-1:0] sub_shift(input logic [BLOCK_BITS-1:0] s);
        logic [BLOCK_BITS-1:0] t;
        int src;
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            src = (i & 3) + 4 * (((i >> 2) + (i & 3)) & 3);
            t[BLOCK_BITS-1-8*i -: 8] = SBOX[s[BLOCK_BITS-1-8*src -: 8]];
        end
        return t;
    endfunction

    function automatic logic [BLOCK_BITS-1:0] inv_shift_sub(input logic [BLOCK_BITS-1:0] s);
        logic [BLOCK_BITS-1:0] t;
        int dst;
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            dst = (i & 3) + 4 * (((i >> 2) + (i & 3)) & 3);
            t[BLOCK_BITS-1-8*dst -: 8] = INV_SBOX[s[BLOCK_BITS-1-8*i -: 8]];
        end
        return t;
    endfunction

    function automatic logic [BLOCK_BITS-1:0] mix(input logic [BLOCK_BITS-1:0] s);
        logic [BLOCK_BITS-1:0] t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
        begin
            a0 = s[BLOCK_BITS-1-32*c -: 8];
            a1 = s[BLOCK_BITS-9-32*c -: 8];
            a2 = s[BLOCK_BITS-17-32*c -: 8];
            a3 = s[BLOCK_BITS-25-32*c -: 8];
            t[BLOCK_BITS-1-32*c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[BLOCK_BITS-9-32*c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[BLOCK_BITS-17-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[BLOCK_BITS-25-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return t;
    endfunction

    function automatic logic [31:0] mul_terms(input logic [7:0] a);
        logic [7:0] x2, x4, x8;
        x2 = xtime(a);
        x4 = xtime(x2);
        x8 = xtime(x4);
        // 14, 11, 13, 9
        return {x8 ^ x4 ^ x2, x8 ^ x2 ^ a, x8 ^ x4 ^ a, x8 ^ a};
    endfunction

    function automatic logic [BLOCK_BITS-1:0] inv_mix(input logic [BLOCK_BITS-1:0] s);
        logic [BLOCK_BITS-1:0] t;
        logic [31:0] m0, m1, m2, m3;
        for (int c = 0; c < 4; c++)
        begin
            m0 = mul_terms(s[BLOCK_BITS-1-32*c -: 8]);
            m1 = mul_terms(s[BLOCK_BITS-9-32*c -: 8]);
            m2 = mul_terms(s[BLOCK_BITS-17-32*c -: 8]);
            m3 = mul_terms(s[BLOCK_BITS-25-32*c -: 8]);
            t[BLOCK_BITS-1-32*c -: 8]  = m0[31:24] ^ m1[23:16] ^ m2[15:8] ^ m3[7:0];
            t[BLOCK_BITS-9-32*c -: 8]  = m0[7:0] ^ m1[31:24] ^ m2[23:16] ^ m3[15:8];
            t[BLOCK_BITS-17-32*c -: 8] = m0[15:8] ^ m1[7:0] ^ m2[31:24] ^ m3[23:16];
            t[BLOCK_BITS-25-32*c -: 8] = m0[23:16] ^ m1[15:8] ^ m2[7:0] ^ m3[31:24];
        end
        return t;
    endfunction

    function automatic logic [BLOCK_BITS-1:0] enc_round(input logic [BLOCK_BITS-1:0] s,
                                                        input logic [BLOCK_BITS-1:0] k,
                                                        input logic                  last);
        logic [BLOCK_BITS-1:0] t;
        t = sub_shift(s);
        if (!last)
        begin
            t = mix(t);
        end
        return t ^ k;
    endfunction

    function automatic logic [BLOCK_BITS-1:0] dec_round(input logic [BLOCK_BITS-1:0] s,
                                                        input logic [BLOCK_BITS-1:0] k,
                                                        input logic                  last);
        logic [BLOCK_BITS-1:0] t;
        t = inv_shift_sub(s) ^ k;
        if (!last)
        begin
            t = inv_mix(t);
        end
        return t;
    endfunction

    function automatic logic [BLOCK_BITS-1:0] key_step(input logic [BLOCK_BITS-1:0] w,
                                                       input logic [7:0]            rc);
        logic [31:0] t, w0, w1, w2, w3;
        t  = {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
        w0 = w[127:96] ^ t;
        w1 = w[95:64] ^ w0;
        w2 = w[63:32] ^ w1;
        w3 = w[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

FILE: hw/rtl/acbc_if.sv
`timescale 1ns / 1ps

interface acbc_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_upper;
    logic [63:0] block_lower;
    logic        final_block;
    logic [4:0]  valid_bytes;

    modport source (output valid, block_upper, block_lower, final_block, valid_bytes,
                    input ready);
    modport sink (input valid, block_upper, block_lower, final_block, valid_bytes,
                  output ready);
endinterface

interface acbc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_upper;
    logic [63:0] out_lower;
    logic        out_last;

    modport source (output valid, out_upper, out_lower, out_last, input ready);
    modport sink (input valid, out_upper, out_lower, out_last, output ready);
endinterface

FILE: hw/rtl/acbc_front.sv
`timescale 1ns / 1ps

module acbc_front (
    input  logic          clk,
    input  logic          rst_n,
    acbc_in_if.sink       blocks,
    input  logic          decrypt_mode,
    input  logic          pad_enable,
    input  logic          cmd_full,
    output logic          cmd_push,
    output acbc_pkg::cmd_t cmd
);
    import acbc_pkg::*;

    logic                  start_reg, start_next;
    logic                  extra_reg, extra_next;
    logic                  accept;
    logic [4:0]            nv;
    logic [7:0]            pad_val;
    logic                  pad_case;
    logic                  need_extra;
    logic [BLOCK_BITS-1:0] in_data;
    logic [BLOCK_BITS-1:0] padded;

    assign blocks.ready = !cmd_full && !extra_reg;
    assign accept       = blocks.valid && blocks.ready;
    assign in_data      = {blocks.block_upper, blocks.block_lower};

    always_comb
    begin
        nv         = (blocks.valid_bytes > 5'(BLOCK_BYTES)) ? 5'(BLOCK_BYTES) : blocks.valid_bytes;
        pad_val    = 8'(5'(BLOCK_BYTES) - nv);
        pad_case   = !decrypt_mode && pad_enable && blocks.final_block;
        need_extra = pad_case && (nv == 5'(BLOCK_BYTES));
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            padded[BLOCK_BITS-1-8*i -: 8] = (5'(i) < nv) ? in_data[BLOCK_BITS-1-8*i -: 8]
                                                         : pad_val;
        end
    end

    always_comb
    begin
        cmd        = '0;
        start_next = start_reg;
        extra_next = extra_reg;
        if (extra_reg)
        begin
            cmd_push    = !cmd_full;
            cmd.data    = {BLOCK_BYTES{8'(BLOCK_BYTES)}};
            cmd.last    = 1'b1;
            cmd.first   = 1'b0;
            cmd.decrypt = 1'b0;
            if (!cmd_full)
            begin
                extra_next = 1'b0;
            end
        end
        else
        begin
            cmd_push    = accept;
            cmd.first   = start_reg;
            cmd.decrypt = decrypt_mode;
            if (pad_case && !need_extra)
            begin
                cmd.data = padded;
                cmd.last = 1'b1;
            end
            else
            begin
                cmd.data = in_data;
                cmd.last = blocks.final_block && !need_extra;
            end
            if (accept)
            begin
                start_next = blocks.final_block;
                extra_next = need_extra;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b1;
            extra_reg <= 1'b0;
        end
        else
        begin
            start_reg <= start_next;
            extra_reg <= extra_next;
        end
    end

endmodule

FILE: hw/rtl/acbc_queue.sv
`timescale 1ns / 1ps

module acbc_queue #(
    parameter int DEPTH = acbc_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  acbc_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output acbc_pkg::cmd_t pop_data,
    output logic           empty
);
    import acbc_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    cmd_t            mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full     = (count_reg == CntW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/acbc_core.sv
`timescale 1ns / 1ps

module acbc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  acbc_pkg::core_cfg_t cfg,
    input  acbc_pkg::cmd_t    cmd,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    acbc_out_if.source        results
);
    import acbc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEXP,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic                  dirty_reg, dirty_next;
    logic [3:0]            round_reg, round_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            rc_reg, rc_next;
    logic [BLOCK_BITS-1:0] st_reg, st_next;
    logic [BLOCK_BITS-1:0] prev_reg, prev_next;
    logic [BLOCK_BITS-1:0] chain_reg, chain_next;
    logic                  dec_reg, dec_next;
    logic                  last_reg, last_next;
    logic [BLOCK_BITS-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic [BLOCK_BITS-1:0] rk_reg [ROUNDS+1];
    logic [3:0]            rk_addr;
    logic [BLOCK_BITS-1:0] rk_cur;
    logic                  rk_we;
    logic [3:0]            rk_waddr;
    logic [BLOCK_BITS-1:0] rk_wdata;
    logic [BLOCK_BITS-1:0] chain_use;
    logic                  out_load;

    assign rk_cur            = rk_reg[rk_addr];
    assign results.valid     = out_valid_reg;
    assign results.out_upper = out_data_reg[BLOCK_BITS-1 -: 64];
    assign results.out_lower = out_data_reg[63:0];
    assign results.out_last  = out_last_reg;

    always_comb
    begin
        state_next    = state_reg;
        dirty_next    = dirty_reg;
        round_next    = round_reg;
        rc_next       = rc_reg;
        st_next       = st_reg;
        prev_next     = prev_reg;
        chain_next    = chain_reg;
        dec_next      = dec_reg;
        last_next     = last_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        cmd_pop       = 1'b0;
        rk_we         = 1'b0;
        rk_waddr      = round_reg;
        rk_wdata      = key_step(st_reg, rc_reg);
        rk_addr       = round_reg;
        out_load      = 1'b0;
        chain_use     = cmd.first ? cfg.iv : chain_reg;

        case (state_reg)
            ST_IDLE:
            begin
                rk_addr = cmd.decrypt ? 4'(ROUNDS) : 4'd0;
                if (dirty_reg)
                begin
                    rk_we      = 1'b1;
                    rk_waddr   = 4'd0;
                    rk_wdata   = cfg.key;
                    st_next    = cfg.key;
                    rc_next    = 8'h01;
                    round_next = 4'd1;
                    dirty_next = 1'b0;
                    state_next = ST_KEXP;
                end
                else if (!cmd_empty)
                begin
                    cmd_pop   = 1'b1;
                    dec_next  = cmd.decrypt;
                    last_next = cmd.last;
                    if (cmd.decrypt)
                    begin
                        st_next    = cmd.data ^ rk_cur;
                        prev_next  = chain_use;
                        chain_next = cmd.data;
                        round_next = 4'(ROUNDS - 1);
                    end
                    else
                    begin
                        st_next    = cmd.data ^ chain_use ^ rk_cur;
                        round_next = 4'd1;
                    end
                    state_next = ST_RUN;
                end
            end
            ST_KEXP:
            begin
                rk_we   = 1'b1;
                st_next = rk_wdata;
                rc_next = xtime(rc_reg);
                if (round_reg == 4'(ROUNDS))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    round_next = round_reg + 1'b1;
                end
            end
            ST_RUN:
            begin
                if (dec_reg)
                begin
                    st_next = dec_round(st_reg, rk_cur, round_reg == 4'd0);
                    if (round_reg == 4'd0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        round_next = round_reg - 1'b1;
                    end
                end
                else
                begin
                    st_next = enc_round(st_reg, rk_cur, round_reg == 4'(ROUNDS));
                    if (round_reg == 4'(ROUNDS))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        round_next = round_reg + 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_load      = 1'b1;
                    out_data_next = dec_reg ? (st_reg ^ prev_reg) : st_reg;
                    out_last_next = last_reg;
                    if (!dec_reg)
                    begin
                        chain_next = st_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg.key_wr)
        begin
            dirty_next = 1'b1;
        end

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && !results.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dirty_reg     <= 1'b1;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dirty_reg     <= dirty_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rc_reg       <= rc_next;
        st_reg       <= st_next;
        prev_reg     <= prev_next;
        chain_reg    <= chain_next;
        dec_reg      <= dec_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        if (rk_we)
        begin
            rk_reg[rk_waddr] <= rk_wdata;
        end
    end

    a_pop_only_when_keys_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == ST_IDLE) && !dirty_reg)
        else $error("command taken while round keys are stale");

    a_round_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN || state_reg == ST_KEXP) |-> round_reg <= 4'(ROUNDS))
        else $error("round counter out of range");

    a_key_write_marks_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.key_wr && state_reg != ST_IDLE) |=> dirty_reg)
        else $error("key write lost");

    a_result_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !results.ready) |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result overwritten");

endmodule

FILE: hw/rtl/aes128_cbc_cipher.sv
`timescale 1ns / 1ps

// Channel   Role    Payload                                             Beat when
// blocks    sink    block_upper, block_lower, final_block, valid_bytes  valid && ready
// results   source  out_upper, out_lower, out_last                      valid && ready
// config    write   cfg_we, cfg_index, cfg_data                         cfg_we
//
// Each block passes through the round unit as one load, ten rounds and one output write.
// A padded full last block yields two results.
// After reset and after a key write the key schedule runs before the next block is taken.
// A two-entry command queue lets the front take blocks while the round unit works;
// the output register holds a result until taken while the next block is loaded.
module aes128_cbc_cipher #(
    parameter int QUEUE_DEPTH = acbc_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  acbc_pkg::reg_idx_t cfg_index,
    input  logic [63:0]        cfg_data,
    acbc_in_if.sink            blocks,
    acbc_out_if.source         results
);
    import acbc_pkg::*;

    logic [63:0] key_upper_reg, key_lower_reg, iv_upper_reg, iv_lower_reg;
    logic        decrypt_mode_reg, pad_enable_reg;
    logic        key_wr;
    core_cfg_t   core_cfg;
    cmd_t        push_cmd, pop_cmd;
    logic        cmd_push, cmd_pop, cmd_full, cmd_empty;

    always_comb
    begin
        case (cfg_index)
            REG_KEY_UPPER, REG_KEY_LOWER: key_wr = cfg_we;
            default:                      key_wr = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg    <= '0;
            key_lower_reg    <= '0;
            iv_upper_reg     <= '0;
            iv_lower_reg     <= '0;
            decrypt_mode_reg <= 1'b0;
            pad_enable_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_UPPER:    key_upper_reg    <= cfg_data;
                REG_KEY_LOWER:    key_lower_reg    <= cfg_data;
                REG_IV_UPPER:     iv_upper_reg     <= cfg_data;
                REG_IV_LOWER:     iv_lower_reg     <= cfg_data;
                REG_DECRYPT_MODE: decrypt_mode_reg <= cfg_data[0];
                REG_PAD_ENABLE:   pad_enable_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign core_cfg.key    = {key_upper_reg, key_lower_reg};
    assign core_cfg.iv     = {iv_upper_reg, iv_lower_reg};
    assign core_cfg.key_wr = key_wr;

    acbc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .blocks       (blocks),
        .decrypt_mode (decrypt_mode_reg),
        .pad_enable   (pad_enable_reg),
        .cmd_full     (cmd_full),
        .cmd_push     (cmd_push),
        .cmd          (push_cmd)
    );

    acbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (push_cmd),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (pop_cmd),
        .empty     (cmd_empty)
    );

    acbc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (core_cfg),
        .cmd       (pop_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .results   (results)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import acbc_pkg::*;

    typedef struct {
        logic [63:0] upper;
        logic [63:0] lower;
        logic        fin;
        logic [4:0]  nbytes;
    } blk_t;

    typedef struct {
        logic [63:0] upper;
        logic [63:0] lower;
        logic        last;
    } res_t;

    typedef struct {
        logic [127:0] data;
        logic         fin;
        logic [4:0]   nbytes;
        logic         has_exp;
        logic [127:0] exp_data;
    } vec_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    reg_idx_t cfg_index;
    logic [63:0] cfg_data;

    acbc_in_if  blocks ();
    acbc_out_if results ();

    aes128_cbc_cipher u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .blocks    (blocks.sink),
        .results   (results.source)
    );

    logic [7:0] sb [256];
    logic [7:0] isb [256];
    logic [127:0] key_reg;
    logic [127:0] iv_reg;
    logic         decrypt_reg;
    logic         pad_reg;
    logic [127:0] chain;
    logic         msg_start;
    logic [127:0] rk [11];

    res_t expected_q [$];
    int   errors;
    int   blocks_sent;
    int   results_seen;
    int   idle_cycles;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic logic [7:0] mul2(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                r ^= a;
            a = mul2(a);
        end
        return r;
    endfunction

    function automatic logic [7:0] byte_at(logic [127:0] s, int i);
        return s[127-8*i -: 8];
    endfunction

    function void expand_schedule();
        logic [7:0] w [176];
        logic [7:0] t [4];
        logic [7:0] rc;
        logic [7:0] tmp;
        rc = 8'h01;
        for (int i = 0; i < 16; i++)
            w[i] = byte_at(key_reg, i);
        for (int i = 16; i < 176; i += 4)
        begin
            for (int j = 0; j < 4; j++)
                t[j] = w[i-4+j];
            if (i % 16 == 0)
            begin
                tmp  = t[0];
                t[0] = sb[t[1]] ^ rc;
                t[1] = sb[t[2]];
                t[2] = sb[t[3]];
                t[3] = sb[tmp];
                rc   = mul2(rc);
            end
            for (int j = 0; j < 4; j++)
                w[i+j] = w[i-16+j] ^ t[j];
        end
        for (int r = 0; r < 11; r++)
            for (int i = 0; i < 16; i++)
                rk[r][127-8*i -: 8] = w[16*r+i];
    endfunction

    function automatic logic [127:0] aes_encrypt(logic [127:0] s);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        s ^= rk[0];
        for (int i = 0; i < 16; i++)
            b[i] = byte_at(s, i);
        for (int r = 1; r <= 10; r++)
        begin
            for (int i = 0; i < 16; i++)
                t[i] = sb[b[(i & 3) + 4 * (((i >> 2) + (i & 3)) & 3)]];
            b = t;
            if (r != 10)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = b[4*c]; a1 = b[4*c+1]; a2 = b[4*c+2]; a3 = b[4*c+3];
                    b[4*c]   = mul2(a0) ^ mul2(a1) ^ a1 ^ a2 ^ a3;
                    b[4*c+1] = a0 ^ mul2(a1) ^ mul2(a2) ^ a2 ^ a3;
                    b[4*c+2] = a0 ^ a1 ^ mul2(a2) ^ mul2(a3) ^ a3;
                    b[4*c+3] = mul2(a0) ^ a0 ^ a1 ^ a2 ^ mul2(a3);
                end
            for (int i = 0; i < 16; i++)
                b[i] ^= byte_at(rk[r], i);
        end
        for (int i = 0; i < 16; i++)
            o[127-8*i -: 8] = b[i];
        return o;
    endfunction

    function automatic logic [127:0] aes_decrypt(logic [127:0] s);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        s ^= rk[10];
        for (int i = 0; i < 16; i++)
            b[i] = byte_at(s, i);
        for (int r = 9; r >= 0; r--)
        begin
            for (int i = 0; i < 16; i++)
                t[(i & 3) + 4 * (((i >> 2) + (i & 3)) & 3)] = isb[b[i]];
            b = t;
            for (int i = 0; i < 16; i++)
                b[i] ^= byte_at(rk[r], i);
            if (r != 0)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = b[4*c]; a1 = b[4*c+1]; a2 = b[4*c+2]; a3 = b[4*c+3];
                    b[4*c]   = gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13) ^ gf_mul(a3, 9);
                    b[4*c+1] = gf_mul(a0, 9) ^ gf_mul(a1, 14) ^ gf_mul(a2, 11) ^ gf_mul(a3, 13);
                    b[4*c+2] = gf_mul(a0, 13) ^ gf_mul(a1, 9) ^ gf_mul(a2, 14) ^ gf_mul(a3, 11);
                    b[4*c+3] = gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, 9) ^ gf_mul(a3, 14);
                end
        end
        for (int i = 0; i < 16; i++)
            o[127-8*i -: 8] = b[i];
        return o;
    endfunction

    function void push_cbc_encrypt(logic [127:0] p, logic last);
        res_t r;
        chain = aes_encrypt(p ^ chain);
        r.upper = chain[127:64];
        r.lower = chain[63:0];
        r.last  = last;
        expected_q.push_back(r);
    endfunction

    function void predict_cbc(blk_t b);
        logic [127:0] p;
        logic [4:0]   n;
        res_t r;
        if (msg_start)
            chain = iv_reg;
        p = {b.upper, b.lower};
        if (decrypt_reg)
        begin
            p = aes_decrypt(p) ^ chain;
            chain = {b.upper, b.lower};
            r.upper = p[127:64];
            r.lower = p[63:0];
            r.last  = b.fin;
            expected_q.push_back(r);
        end
        else if (pad_reg && b.fin)
        begin
            n = (b.nbytes > 16) ? 5'd16 : b.nbytes;
            if (n < 16)
            begin
                for (int i = 0; i < 16; i++)
                    if (i >= n)
                        p[127-8*i -: 8] = 8'(16 - n);
                push_cbc_encrypt(p, 1'b1);
            end
            else
            begin
                push_cbc_encrypt(p, 1'b0);
                push_cbc_encrypt({16{8'h10}}, 1'b1);
            end
        end
        else
            push_cbc_encrypt(p, b.fin);
        msg_start = b.fin;
        if (b.fin)
            chain = iv_reg;
    endfunction

    task automatic report(string what, logic [127:0] got, logic [127:0] exp);
        errors++;
        $display("mismatch %s at result %0d: got %h exp %h", what, results_seen, got, exp);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
        begin
            res_t e;
            if (expected_q.size() == 0)
                report("unexpected beat", {results.out_upper, results.out_lower}, '0);
            else
            begin
                e = expected_q.pop_front();
                if (results.out_upper !== e.upper)
                    report("out_upper", results.out_upper, e.upper);
                if (results.out_lower !== e.lower)
                    report("out_lower", results.out_lower, e.lower);
                if (results.out_last !== e.last)
                    report("out_last", results.out_last, e.last);
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            results.ready <= 1'b0;
        else
            case (($urandom_range(0, 2) == 0) ? ($urandom_range(0, 3) ? 1 : 0) : 2)
                0: results.ready <= 1'b0;
                1: results.ready <= ($urandom_range(0, 3) != 0);
                default: results.ready <= 1'b1;
            endcase
    end

    always @(posedge clk)
    begin
        if ((blocks.valid && blocks.ready) || (results.valid && results.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_KEY_UPPER: key_reg[127:64] = val;
            REG_KEY_LOWER: key_reg[63:0]   = val;
            REG_IV_UPPER:  iv_reg[127:64]  = val;
            REG_IV_LOWER:  iv_reg[63:0]    = val;
            REG_DECRYPT_MODE: decrypt_reg  = val[0];
            REG_PAD_ENABLE:   pad_reg      = val[0];
            default: ;
        endcase
        if (idx == REG_KEY_UPPER || idx == REG_KEY_LOWER)
            expand_schedule();
    endtask

    task automatic send_block(blk_t b);
        if ($urandom_range(0, 4) == 0)
        begin
            blocks.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        blocks.valid       <= 1'b1;
        blocks.block_upper <= b.upper;
        blocks.block_lower <= b.lower;
        blocks.final_block <= b.fin;
        blocks.valid_bytes <= b.nbytes;
        predict_cbc(b);
        do
            @(posedge clk);
        while (!blocks.ready);
        blocks_sent++;
    endtask

    task automatic drain();
        blocks.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_mode(logic [63:0] ku, logic [63:0] kl, logic [63:0] iu,
                            logic [63:0] il, logic dec, logic pad);
        drain();
        write_reg(REG_KEY_UPPER, ku);
        write_reg(REG_KEY_LOWER, kl);
        write_reg(REG_IV_UPPER, iu);
        write_reg(REG_IV_LOWER, il);
        write_reg(REG_DECRYPT_MODE, {63'd0, dec});
        write_reg(REG_PAD_ENABLE, {63'd0, pad});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    vec_t directed [$];

    initial
    begin
        blk_t b;
        res_t e;
        int   nmsg;
        int   counts [7];
        for (int i = 0; i < 256; i++)
        begin
            sb[i]  = SBOX[i];
            isb[i] = INV_SBOX[i];
        end
        errors = 0; blocks_sent = 0; results_seen = 0; idle_cycles = 0;
        key_reg = '0; iv_reg = '0; decrypt_reg = 0; pad_reg = 0;
        chain = '0; msg_start = 1'b1;
        expand_schedule();
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = REG_KEY_UPPER; cfg_data = '0;
        blocks.valid = 1'b0; blocks.block_upper = '0; blocks.block_lower = '0;
        blocks.final_block = 1'b0; blocks.valid_bytes = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // zero key, zero IV, zero block: the all-zero AES-128 vector
        directed.push_back('{128'd0, 1'b1, 5'd0, 1'b1,
                             128'h66e94bd4ef8a2c3b884cfa59ca342b2e});
        directed.push_back('{'1, 1'b0, 5'd31, 1'b0, '0});
        directed.push_back('{'1, 1'b1, 5'd0, 1'b0, '0});
        foreach (directed[i])
        begin
            b = '{directed[i].data[127:64], directed[i].data[63:0],
                  directed[i].fin, directed[i].nbytes};
            send_block(b);
            if (directed[i].has_exp)
            begin
                e = expected_q[expected_q.size() - 1];
                if ({e.upper, e.lower} !== directed[i].exp_data)
                    report("known vector", {e.upper, e.lower}, directed[i].exp_data);
                drain();
            end
        end

        // padding corner cases: count 0, mid, 15, 16, above 16
        set_mode(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'h0001020304050607,
                 64'h08090a0b0c0d0e0f, 1'b0, 1'b1);
        counts = '{0, 1, 7, 15, 16, 17, 31};
        foreach (counts[k])
        begin
            send_block('{rand64(), rand64(), 1'b0, 5'(counts[k])});
            send_block('{rand64(), rand64(), 1'b1, 5'(counts[k])});
        end

        // decrypt with an all-ones key and IV
        set_mode('1, '1, '1, '1, 1'b1, 1'b1);
        send_block('{'1, '1, 1'b0, 5'd3});
        send_block('{'0, '0, 1'b1, 5'd16});

        // key change in the middle of a message
        set_mode(rand64(), rand64(), rand64(), rand64(), 1'b0, 1'b0);
        send_block('{rand64(), rand64(), 1'b0, 5'd0});
        drain();
        write_reg(REG_KEY_LOWER, rand64());
        send_block('{rand64(), rand64(), 1'b1, 5'd0});

        nmsg = 0;
        while (blocks_sent < 520)
        begin
            if (nmsg % 6 == 0)
                set_mode(rand64(), rand64(), rand64(), rand64(),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            for (int n = $urandom_range(1, 8); n > 0; n--)
                send_block('{rand64(), rand64(), 1'(n == 1 || $urandom_range(0, 15) == 0),
                             ($urandom_range(0, 3) == 0) ? 5'd16 : 5'($urandom_range(0, 31))});
            nmsg++;
        end
        drain();
        $display("sent %0d blocks in %0d messages, checked %0d results",
                 blocks_sent, nmsg, results_seen);
        $display("covered encrypt and decrypt, padding on and off, all byte counts");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
